FILE: src/brgrm_pkg.sv
package brgrm_pkg;

	localparam int RANK_COUNT = 64;
	localparam int RANK_BITS  = $clog2(RANK_COUNT);
	localparam int COUNT_BITS = 32;
	localparam int VALUE_W    = 32;
	localparam int DEPTH_W    = 6;
	localparam int OFFSET_W   = 6;
	localparam int FIELD_W    = 32;

	localparam logic OP_TARGET = 1'b0;
	localparam logic OP_SOURCE = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [VALUE_W-1:0] item_value;
		logic [DEPTH_W-1:0] depth;
	} item_t;

	typedef struct packed {
		logic               is_source;
		logic               found_match;
		logic [DEPTH_W-1:0] chosen_rank;
		logic [FIELD_W-1:0] count_at_rank;
		logic [FIELD_W-1:0] matched_at_rank;
		logic [FIELD_W-1:0] matched_total;
		logic [FIELD_W-1:0] unmatched_total;
		logic [FIELD_W-1:0] remaining_total;
		logic               have_first_miss;
		logic [VALUE_W-1:0] first_miss_value;
		logic [DEPTH_W-1:0] first_miss_depth;
	} res_t;

	typedef struct packed {
		logic                 found;
		logic [RANK_BITS-1:0] rank;
	} search_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

endpackage

FILE: src/brgrm_bank_ram.sv
module brgrm_bank_ram #(
	parameter int WIDTH     = 64,
	parameter int DEPTH     = 64,
	parameter int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [WIDTH-1:0]     rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [WIDTH-1:0]     wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: src/brgrm_rank_search.sv
module brgrm_rank_search
	import brgrm_pkg::*;
(
	input  logic                  opcode,
	input  logic [DEPTH_W-1:0]    depth,
	input  logic [OFFSET_W-1:0]   offset,
	input  logic [RANK_COUNT-1:0] mask,
	output search_t               result
);

	logic [DEPTH_W:0]     sum;
	logic [RANK_BITS-1:0] limit;

	always_comb begin
		sum = {1'b0, depth} + (DEPTH_W+1)'(offset);
		// clamp the search limit to the top bucket
		if (sum > (DEPTH_W+1)'(RANK_COUNT - 1)) begin
			limit = RANK_BITS'(RANK_COUNT - 1);
		end else begin
			limit = RANK_BITS'(sum);
		end
	end

	always_comb begin
		result = '0;
		if (opcode == OP_TARGET) begin
			if ((DEPTH_W+1)'(depth) > (DEPTH_W+1)'(RANK_COUNT - 1)) begin
				result.rank = RANK_BITS'(RANK_COUNT - 1);
			end else begin
				result.rank = RANK_BITS'(depth);
			end
		end else begin
			// highest set bit at or below the limit wins
			for (int i = 0; i < RANK_COUNT; i++) begin
				if (mask[i] && (RANK_BITS'(i) <= limit)) begin
					result.found = 1'b1;
					result.rank  = RANK_BITS'(i);
				end
			end
		end
	end

endmodule

FILE: src/bucketed_greedy_rank_matcher_core.sv
// Greedy rank matcher over RANK_COUNT buckets.
//
// Item channel (item_valid / item_stall / item): opcode 0 adds one target
// unit at rank depth; opcode 1 presents a source that claims one unit from
// the highest nonempty bucket at or below min(depth + rank offset, top).
// Result channel (res_valid / res_stall / res): exactly one item per input,
// carrying the chosen rank, its counts, the running totals and the first
// miss latch.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes the rank offset;
// always ready, write only while idle.
//
// Timing: an item is taken in the idle cycle, where the nonempty mask and a
// priority encoder pick the rank and the bucket RAM read is issued; in the
// update state, once the result register is free, the bucket is modified
// and written back and the result register loaded. No new item is taken
// until that update is done, as the RAM read is registered. While the
// receiver stalls a waiting result, the update holds and the
// input stalls. Reset clears counters, mask and per-bucket valid bits at
// once; no clearing pass is needed.
module bucketed_greedy_rank_matcher_core
	import brgrm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  item_t               item,
	output logic                res_valid,
	input  logic                res_stall,
	output res_t                res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [OFFSET_W-1:0] cfg_data
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	state_t state_q, state_d;

	logic [OFFSET_W-1:0]   offset_q;
	logic [RANK_COUNT-1:0] mask_q;
	logic [RANK_COUNT-1:0] valid_q;
	logic [COUNT_BITS-1:0] matched_sum_q, unmatched_sum_q, remaining_sum_q;
	logic                  miss_seen_q;
	logic [VALUE_W-1:0]    miss_value_q;
	logic [DEPTH_W-1:0]    miss_depth_q;

	item_t                 item_s1;
	logic [RANK_BITS-1:0]  rank_s1;
	logic                  found_s1;
	logic                  hit_valid_s1;

	res_t                  res_q;
	logic                  res_valid_q;

	search_t               search;
	logic                  item_accept;
	logic                  advance;
	logic                  do_update;

	logic [2*COUNT_BITS-1:0] rd_data;
	logic [2*COUNT_BITS-1:0] wr_data;
	logic                    wr_en;

	logic [COUNT_BITS-1:0] avail_cur, matched_cur, avail_new, matched_new;
	logic [COUNT_BITS-1:0] matched_sum_d, unmatched_sum_d, remaining_sum_d;
	logic                  is_src, target_ok, src_miss, first_miss;
	res_t                  res_d;

	// rank pick straight from the mask
	brgrm_rank_search u_search (
		.opcode (item.opcode),
		.depth  (item.depth),
		.offset (offset_q),
		.mask   (mask_q),
		.result (search)
	);

	// bucket RAM: {matched, available} per rank
	brgrm_bank_ram #(
		.WIDTH (2*COUNT_BITS),
		.DEPTH (RANK_COUNT)
	) u_ram (
		.clk     (clk),
		.rd_en   (item_accept),
		.rd_addr (search.rank),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (rank_s1),
		.wr_data (wr_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (advance) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		item_stall  = (state_q != ST_IDLE);
		item_accept = item_valid && (state_q == ST_IDLE);
		advance     = !res_valid_q || !res_stall;
		do_update   = (state_q == ST_UPDATE) && advance;
		cfg_ready   = 1'b1;
	end

	// modify: a never-written bucket reads as zero
	always_comb begin
		is_src      = (item_s1.opcode == OP_SOURCE);
		avail_cur   = hit_valid_s1 ? rd_data[COUNT_BITS-1:0] : '0;
		matched_cur = hit_valid_s1 ? rd_data[2*COUNT_BITS-1:COUNT_BITS] : '0;
		target_ok   = !is_src && (avail_cur != COUNT_MAX);
		src_miss    = is_src && !found_s1;
		first_miss  = src_miss && !miss_seen_q;

		avail_new       = avail_cur;
		matched_new     = matched_cur;
		matched_sum_d   = matched_sum_q;
		unmatched_sum_d = unmatched_sum_q;
		remaining_sum_d = remaining_sum_q;

		if (target_ok) begin
			avail_new = avail_cur + COUNT_BITS'(1);
			if (remaining_sum_q != COUNT_MAX) remaining_sum_d = remaining_sum_q + COUNT_BITS'(1);
		end
		if (is_src && found_s1) begin
			avail_new = avail_cur - COUNT_BITS'(1);
			if (matched_cur != COUNT_MAX) matched_new = matched_cur + COUNT_BITS'(1);
			if (matched_sum_q != COUNT_MAX) matched_sum_d = matched_sum_q + COUNT_BITS'(1);
			if (remaining_sum_q != '0) remaining_sum_d = remaining_sum_q - COUNT_BITS'(1);
		end
		if (src_miss && (unmatched_sum_q != COUNT_MAX)) begin
			unmatched_sum_d = unmatched_sum_q + COUNT_BITS'(1);
		end

		wr_en   = do_update && (target_ok || (is_src && found_s1));
		wr_data = {matched_new, avail_new};

		res_d.is_source        = is_src;
		res_d.found_match      = is_src && found_s1;
		res_d.chosen_rank      = src_miss ? '0 : DEPTH_W'(rank_s1);
		res_d.count_at_rank    = src_miss ? '0 : FIELD_W'(avail_new);
		res_d.matched_at_rank  = src_miss ? '0 : FIELD_W'(matched_new);
		res_d.matched_total    = FIELD_W'(matched_sum_d);
		res_d.unmatched_total  = FIELD_W'(unmatched_sum_d);
		res_d.remaining_total  = FIELD_W'(remaining_sum_d);
		res_d.have_first_miss  = miss_seen_q || src_miss;
		res_d.first_miss_value = first_miss ? item_s1.item_value : miss_value_q;
		res_d.first_miss_depth = first_miss ? item_s1.depth : miss_depth_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			offset_q        <= '0;
			mask_q          <= '0;
			valid_q         <= '0;
			matched_sum_q   <= '0;
			unmatched_sum_q <= '0;
			remaining_sum_q <= '0;
			miss_seen_q     <= 1'b0;
			miss_value_q    <= '0;
			miss_depth_q    <= '0;
			res_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) offset_q <= cfg_data;
			if (do_update) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (do_update) begin
				matched_sum_q   <= matched_sum_d;
				unmatched_sum_q <= unmatched_sum_d;
				remaining_sum_q <= remaining_sum_d;
				if (first_miss) begin
					miss_seen_q  <= 1'b1;
					miss_value_q <= item_s1.item_value;
					miss_depth_q <= item_s1.depth;
				end
				if (wr_en) begin
					valid_q[rank_s1] <= 1'b1;
					// drop the mask bit once the bucket runs dry
					mask_q[rank_s1]  <= (avail_new != '0);
				end
			end
		end
	end

	// item and pick, held through the update
	always_ff @(posedge clk) begin
		if (item_accept) begin
			item_s1      <= item;
			rank_s1      <= search.rank;
			found_s1     <= search.found;
			hit_valid_s1 <= valid_q[search.rank];
		end
		if (do_update) res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	// a set mask bit must mean a nonempty bucket
	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) && is_src && found_s1 |-> (avail_cur != '0))
		else $error("source matched an empty bucket");

	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		item_accept |=> (state_q == ST_UPDATE))
		else $error("accepted item did not enter update");

	a_update_result: assert property (@(posedge clk) disable iff (!arst_n)
		do_update |=> (res_valid_q && (state_q == ST_IDLE)))
		else $error("update did not produce a result");
`endif

endmodule
